// ===== sv/deq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Action carried in tuser of each input beat.
    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_LIST_FWD   = 3'd4,
        ACT_LIST_BWD   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } state_t;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 4;

endpackage

`default_nettype wire

// ===== sv/double_ended_queue_core.sv =====
// A result beat is loaded into the output register from the execute state once that
// register is free. No new input is taken until the last beat of an action is loaded; a
// listing emits one beat per cycle from the single RAM read port while the output is free.
// The input may be accepted while the previous result beat still waits on the output.
// Reset clears the front and rear pointers, the entry count and the sequencer; the slot
// RAM is not cleared, since data read from an unoccupied slot never reaches the output.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
    parameter int DEPTH      = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value_in[31:0]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // value_out[31:0], occupancy[35:32],
                                        // is_full[36], is_empty[37], zero fill[39:38]
    output logic      [1:0]  m_tuser,   // status[1:0]
    output logic             m_tlast
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OUT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_TOP) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_TOP : p - PTR_W'(1);
    endfunction

    deq_pkg::state_t  state_reg, state_next;
    deq_pkg::action_t action_reg;
    logic [31:0]      value_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [31:0]           out_val_reg;
    deq_pkg::status_t      out_status_reg;
    logic                  out_last_reg;
    logic [3:0]            out_occ_reg;
    logic                  out_full_reg;
    logic                  out_empty_reg;

    logic                  ram_wr_en;
    logic [PTR_W-1:0]      ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [PTR_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic                  in_accept;
    logic                  out_free;
    logic                  load_out;
    logic [DATA_WIDTH-1:0] ld_val;
    deq_pkg::status_t      ld_status;
    logic                  ld_last;
    logic [PTR_W-1:0]      list_ptr;
    deq_pkg::action_t      in_action;

    assign in_action   = deq_pkg::action_t'(s_tuser);
    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign ram_wr_data = DATA_WIDTH'(value_reg[OUT_W-1:0]);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= deq_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            ptr_reg      <= '0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            remain_reg   <= remain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= in_action;
            value_reg  <= s_tdata;
        end
        if (load_out)
        begin
            out_val_reg    <= 32'(ld_val[OUT_W-1:0]);
            out_status_reg <= ld_status;
            out_last_reg   <= ld_last;
            out_occ_reg    <= 4'(count_next);
            out_full_reg   <= (count_next == CNT_FULL);
            out_empty_reg  <= (count_next == '0);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        remain_next   = remain_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = head_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = head_reg;
        load_out      = 1'b0;
        ld_val        = '0;
        ld_status     = deq_pkg::STAT_OK;
        ld_last       = 1'b1;
        list_ptr      = ptr_reg;
        s_tready      = (state_reg == deq_pkg::ST_IDLE);

        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_action)
                        deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR,
                        deq_pkg::ACT_POP_REAR, deq_pkg::ACT_LIST_BWD:
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = tail_reg;
                            state_next  = deq_pkg::ST_EXEC;
                        end
                        deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_LIST_FWD:
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg;
                            state_next  = deq_pkg::ST_EXEC;
                        end
                        default:
                        begin
                            // Undefined actions are dropped without a result.
                            state_next = deq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            deq_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = deq_pkg::ST_IDLE;
                    unique case (action_reg)
                        deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                ld_status = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    head_next   = '0;
                                    tail_next   = '0;
                                    ram_wr_addr = '0;
                                end
                                else if (action_reg == deq_pkg::ACT_PUSH_FRONT)
                                begin
                                    head_next   = wrap_dec(head_reg);
                                    ram_wr_addr = wrap_dec(head_reg);
                                end
                                else
                                begin
                                    tail_next   = wrap_inc(tail_reg);
                                    ram_wr_addr = wrap_inc(tail_reg);
                                end
                            end
                        end
                        deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_REAR:
                        begin
                            if (count_reg == '0)
                            begin
                                ld_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ld_val     = ram_rd_data;
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1))
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else if (action_reg == deq_pkg::ACT_POP_FRONT)
                                begin
                                    head_next = wrap_inc(head_reg);
                                end
                                else
                                begin
                                    tail_next = wrap_dec(tail_reg);
                                end
                            end
                        end
                        deq_pkg::ACT_LIST_FWD, deq_pkg::ACT_LIST_BWD:
                        begin
                            if (count_reg == '0)
                            begin
                                ld_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // First entry is already read; fetch the next one now.
                                ld_val      = ram_rd_data;
                                ld_last     = (count_reg == CNT_W'(1));
                                list_ptr    = (action_reg == deq_pkg::ACT_LIST_FWD) ?
                                              wrap_inc(head_reg) : wrap_dec(tail_reg);
                                ptr_next    = list_ptr;
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = list_ptr;
                                remain_next = count_reg - CNT_W'(1);
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = deq_pkg::ST_LIST;
                                end
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end

            deq_pkg::ST_LIST:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    ld_val      = ram_rd_data;
                    ld_last     = (remain_reg == CNT_W'(1));
                    remain_next = remain_reg - CNT_W'(1);
                    list_ptr    = (action_reg == deq_pkg::ACT_LIST_FWD) ?
                                  wrap_inc(ptr_reg) : wrap_dec(ptr_reg);
                    ptr_next    = list_ptr;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = list_ptr;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = deq_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_empty_reg, out_full_reg, out_occ_reg, out_val_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count exceeds the store depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("pointers not parked at slot zero while empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result beat overwritten before it was taken");

    a_list_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == deq_pkg::ST_LIST) |-> (remain_reg != '0 && remain_reg < CNT_FULL))
        else $error("listing counter out of range");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |=> (state_reg == deq_pkg::ST_IDLE && count_reg != '0))
        else $error("slot write outside a completed push");

endmodule

`default_nettype wire

// ===== sv/deq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_core_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_core_tb;

    localparam int QUEUE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [31:0]      value;
        deq_pkg::status_t status;
        logic             last;
        logic [3:0]       occupancy;
        logic             full;
        logic             empty;
    } deq_result_t;

    // Mirrors the deque and keeps the beats it still owes on the output.
    class deque_scoreboard;
        logic [31:0]  slots [QUEUE_DEPTH];
        int unsigned  front_idx;
        int unsigned  rear_idx;
        int unsigned  fill_level;
        deq_result_t  owed_q[$];
        int unsigned  mismatches;

        function new();
            front_idx  = 0;
            rear_idx   = 0;
            fill_level = 0;
            mismatches = 0;
        endfunction

        function void owe_beat(logic [31:0] value, deq_pkg::status_t status, logic last);
            deq_result_t r;
            r.value     = value;
            r.status    = status;
            r.last      = last;
            r.occupancy = fill_level[3:0];
            r.full      = (fill_level == QUEUE_DEPTH);
            r.empty     = (fill_level == 0);
            owed_q.push_back(r);
        endfunction

        function void note_input(logic [2:0] act, logic [31:0] value);
            int unsigned p;
            case (act)
                deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR:
                begin
                    if (fill_level == QUEUE_DEPTH)
                    begin
                        owe_beat(32'd0, deq_pkg::STAT_FULL, 1'b1);
                    end
                    else
                    begin
                        if (fill_level == 0)
                        begin
                            front_idx = 0;
                            rear_idx  = 0;
                            slots[0]  = value;
                        end
                        else if (act == deq_pkg::ACT_PUSH_FRONT)
                        begin
                            front_idx = (front_idx == 0) ? QUEUE_DEPTH - 1 : front_idx - 1;
                            slots[front_idx] = value;
                        end
                        else
                        begin
                            rear_idx = (rear_idx == QUEUE_DEPTH - 1) ? 0 : rear_idx + 1;
                            slots[rear_idx] = value;
                        end
                        fill_level++;
                        owe_beat(32'd0, deq_pkg::STAT_OK, 1'b1);
                    end
                end
                deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_REAR:
                begin
                    if (fill_level == 0)
                    begin
                        owe_beat(32'd0, deq_pkg::STAT_EMPTY, 1'b1);
                    end
                    else
                    begin
                        if (act == deq_pkg::ACT_POP_FRONT)
                        begin
                            p = front_idx;
                            front_idx = (front_idx == QUEUE_DEPTH - 1) ? 0 : front_idx + 1;
                        end
                        else
                        begin
                            p = rear_idx;
                            rear_idx = (rear_idx == 0) ? QUEUE_DEPTH - 1 : rear_idx - 1;
                        end
                        fill_level--;
                        // An emptied queue parks both pointers at slot zero.
                        if (fill_level == 0)
                        begin
                            front_idx = 0;
                            rear_idx  = 0;
                        end
                        owe_beat(slots[p], deq_pkg::STAT_OK, 1'b1);
                    end
                end
                deq_pkg::ACT_LIST_FWD, deq_pkg::ACT_LIST_BWD:
                begin
                    if (fill_level == 0)
                    begin
                        owe_beat(32'd0, deq_pkg::STAT_EMPTY, 1'b1);
                    end
                    else
                    begin
                        p = (act == deq_pkg::ACT_LIST_FWD) ? front_idx : rear_idx;
                        for (int k = 0; k < fill_level; k++)
                        begin
                            owe_beat(slots[p], deq_pkg::STAT_OK, k == fill_level - 1);
                            if (act == deq_pkg::ACT_LIST_FWD)
                                p = (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
                            else
                                p = (p == 0) ? QUEUE_DEPTH - 1 : p - 1;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_beat(logic [39:0] data, logic [1:0] user, logic last);
            deq_result_t want;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: data=%h user=%0d last=%0d",
                             data, user, last);
                return;
            end
            want = owed_q.pop_front();
            if (data[31:0] !== want.value || data[35:32] !== want.occupancy ||
                data[36] !== want.full || data[37] !== want.empty ||
                data[39:38] !== 2'b00 || user !== want.status || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected value=%h status=%0d last=%0d occ=%0d %s%0d %s%0d",
                             want.value, want.status, want.last, want.occupancy,
                             "full=", want.full, "empty=", want.empty);
                    $display("          got value=%h status=%0d last=%0d occ=%0d %s%0d %s%0d %s%b",
                             data[31:0], user, last, data[35:32], "full=", data[36],
                             "empty=", data[37], "fill=", data[39:38]);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int unsigned     send_idle_pct = 29;
    int unsigned     recv_idle_pct = 62;
    int unsigned     cycle_count = 0;
    deque_scoreboard sb = new();

    double_ended_queue_core #(
        .DEPTH      (QUEUE_DEPTH),
        .DATA_WIDTH (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side: check each accepted beat, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [2:0] act, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(act, value);
    endtask

    // Switches at random between filling and draining stretches so that both the full
    // and the empty corner are hit repeatedly.
    task automatic random_items(input int count);
        logic [2:0]  act;
        logic [31:0] value;
        int          done;
        int unsigned pick;
        int unsigned push_bias;
        done = 0;
        push_bias = 70;
        while (done < count)
        begin
            if (done % 20 == 0)
                push_bias = $urandom_range(1) ? 70 : 30;
            pick = $urandom_range(99);
            if (pick < 4)
                act = 3'($urandom_range(7, 6));
            else if (pick < 18)
                act = $urandom_range(1) ? deq_pkg::ACT_LIST_FWD : deq_pkg::ACT_LIST_BWD;
            else if ($urandom_range(99) < push_bias)
                act = $urandom_range(1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_REAR;
            else
                act = $urandom_range(1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_REAR;
            case ($urandom_range(9))
                0: value = 32'h8000_0000;
                1: value = 32'h7fff_ffff;
                2: value = 32'hffff_ffff;
                3: value = 32'h0000_0000;
                default: value = $urandom();
            endcase
            send_item(act, value);
            if (act <= deq_pkg::ACT_LIST_BWD)
                done++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Everything refused on the empty queue after reset.
        send_item(deq_pkg::ACT_POP_FRONT, 32'd0);
        send_item(deq_pkg::ACT_POP_REAR, 32'd0);
        send_item(deq_pkg::ACT_LIST_FWD, 32'd0);
        send_item(deq_pkg::ACT_LIST_BWD, 32'd0);
        // Rear pop at slot zero that also empties the queue.
        send_item(deq_pkg::ACT_PUSH_REAR, 32'h8000_0000);
        send_item(deq_pkg::ACT_POP_REAR, 32'd0);
        // Front push from slot zero wraps to the top slot.
        send_item(deq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
        send_item(deq_pkg::ACT_PUSH_FRONT, 32'hffff_ffff);
        send_item(deq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
        send_item(deq_pkg::ACT_LIST_BWD, 32'd0);
        repeat (5)
            send_item(deq_pkg::ACT_PUSH_REAR, $urandom());
        // Queue is full now.
        send_item(deq_pkg::ACT_PUSH_FRONT, 32'h1234_5678);
        send_item(deq_pkg::ACT_PUSH_REAR, 32'h8765_4321);
        send_item(deq_pkg::ACT_LIST_FWD, 32'd0);
        send_item(deq_pkg::ACT_LIST_BWD, 32'd0);
        send_item(3'd6, 32'hdead_beef);
        send_item(3'd7, 32'h5555_aaaa);
        send_item(deq_pkg::ACT_POP_FRONT, 32'd0);
        send_item(deq_pkg::ACT_POP_REAR, 32'd0);
        send_item(deq_pkg::ACT_LIST_FWD, 32'd0);

        random_items(40);
        send_idle_pct = 62;
        recv_idle_pct = 29;
        random_items(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(50);
        s_tvalid <= 1'b0;

        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
